[src/esl_pkg.sv]
// ----------------------------------------------------------------------------
// esl_pkg
// Shared constants, codes and stage payload types of the encoder segment
// linearizer. The segment width is a power of two: segment and offset come
// from a split of the angle.
// ----------------------------------------------------------------------------
package esl_pkg;

	// table geometry
	localparam int NUM_SEGMENTS  = 8;
	localparam int SEGMENT_WIDTH = 2048;
	localparam int TABLE_LIMIT   = NUM_SEGMENTS * SEGMENT_WIDTH;

	// field widths
	localparam int ANGLE_W     = 14;
	localparam int INDEX_W     = 3;
	localparam int ENTRY_W     = 15;
	localparam int SPAN_W      = 16;
	localparam int ELEC_W      = 17;

	// derived widths
	localparam int SEG_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
	localparam int OFF_W  = $clog2(SEGMENT_WIDTH);
	localparam int PROD_W = OFF_W + SPAN_W + 1;

	// input item operation codes
	typedef enum logic {
		OP_CONVERT = 1'b0,
		OP_WRITE   = 1'b1
	} esl_op_t;

	// one calibration table entry
	typedef struct packed {
		logic        [ENTRY_W-1:0] lo_angle;
		logic        [ENTRY_W-1:0] hi_angle;
		logic signed [SPAN_W-1:0]  span;
	} esl_entry_t;

	// payload after the table read
	typedef struct packed {
		esl_entry_t         entry;
		logic [OFF_W-1:0]   offset;
	} esl_s2_t;

	// payload after the multiply
	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic        [ENTRY_W-1:0] lo_angle;
		logic        [ENTRY_W-1:0] hi_angle;
	} esl_s3_t;

endpackage

[src/encoder_segment_linearizer.sv]
// ----------------------------------------------------------------------------
// encoder_segment_linearizer
// Piecewise-linear correction of a raw sensor angle into an electrical angle.
//
// Input channel (in_valid/in_ready): operation selects convert or table write.
//   A convert transfer gives one result; a write transfer loads one segment
//   entry and gives none. Entries must be written before read; not enforced.
// Output channel (out_valid/out_ready): one electric_angle per convert.
// Config channel (cfg_valid/cfg_ready): cfg_data bit 0 is count_up, always
//   ready; write it only while no convert is in flight.
// Stages: input split, table memory read, multiply, and divide and base add
//   into the output register, each a register that holds one item.
// Throughput: one item per cycle while out_ready stays high, since each of
//   the four register stages takes a new item whenever the next can move.
// Reset: stage valid bits clear and count_up returns to 1; the table contents
//   stay undefined until written.
// Stall: a held result keeps its stage, earlier stages fill their bubbles, and
//   in_ready drops only when all four stages are occupied.
// ----------------------------------------------------------------------------
module encoder_segment_linearizer import esl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [ANGLE_W-1:0]       sensor_angle,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic [ENTRY_W-1:0]       entry_min,
	input  logic [ENTRY_W-1:0]       entry_max,
	input  logic signed [SPAN_W-1:0] entry_span,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ELEC_W-1:0] electric_angle
);

	logic    count_up_q;
	logic    tbl_valid;
	logic    mul_ready;
	esl_s2_t tbl_data;
	logic    mul_valid;
	logic    fin_ready;
	esl_s3_t mul_data;

	assign cfg_ready = 1'b1;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_up_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			count_up_q <= cfg_data;
		end
	end

	// input split and table read
	esl_table u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sensor_angle (sensor_angle),
		.entry_index  (entry_index),
		.entry_min    (entry_min),
		.entry_max    (entry_max),
		.entry_span   (entry_span),
		.out_valid    (tbl_valid),
		.out_ready    (mul_ready),
		.out_data     (tbl_data)
	);

	// offset times span
	esl_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tbl_valid),
		.in_ready  (mul_ready),
		.in_data   (tbl_data),
		.out_valid (mul_valid),
		.out_ready (fin_ready),
		.out_data  (mul_data)
	);

	// divide, base and saturation
	esl_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.count_up       (count_up_q),
		.in_valid       (mul_valid),
		.in_ready       (fin_ready),
		.in_data        (mul_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.electric_angle (electric_angle)
	);

endmodule

[src/esl_table.sv]
// ----------------------------------------------------------------------------
// esl_table
// Input stage and calibration table. Splits the angle into segment and offset,
// stores table writes and reads the segment entry from a synchronous memory.
// ----------------------------------------------------------------------------
module esl_table import esl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [ANGLE_W-1:0]       sensor_angle,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic [ENTRY_W-1:0]       entry_min,
	input  logic [ENTRY_W-1:0]       entry_max,
	input  logic signed [SPAN_W-1:0] entry_span,
	output logic                     out_valid,
	input  logic                     out_ready,
	output esl_s2_t                  out_data
);

	logic             v_s1;
	logic [SEG_W-1:0] seg_s1;
	logic [OFF_W-1:0] off_s1;
	logic             v_s2;
	esl_s2_t          data_s2;

	esl_entry_t       seg_mem [NUM_SEGMENTS];

	logic             ready_s1;
	logic             ready_s2;
	logic             accept;
	logic             conv_en;
	logic             wr_en;
	logic [31:0]      angle_ext;
	logic [31:0]      angle_sat;
	logic [SEG_W-1:0] seg_in;
	logic [OFF_W-1:0] off_in;
	logic [SEG_W-1:0] wr_idx;
	esl_entry_t       wr_entry;

	// stage handshake, bubbles collapse
	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign accept   = in_valid && in_ready;
	assign conv_en  = accept && (operation == OP_CONVERT);
	assign wr_en    = accept && (operation == OP_WRITE) &&
	                  (32'(entry_index) < 32'(NUM_SEGMENTS));

	// clamp to the last table angle, then split into segment and offset
	assign angle_ext = 32'(sensor_angle);
	assign angle_sat = (angle_ext >= 32'(TABLE_LIMIT)) ? 32'(TABLE_LIMIT - 1) : angle_ext;
	assign seg_in    = SEG_W'(angle_sat >> OFF_W);
	assign off_in    = angle_sat[OFF_W-1:0];

	// table write data
	assign wr_idx            = SEG_W'(32'(entry_index));
	assign wr_entry.lo_angle = entry_min;
	assign wr_entry.hi_angle = entry_max;
	assign wr_entry.span     = entry_span;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= conv_en;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (conv_en) begin
			seg_s1 <= seg_in;
			off_s1 <= off_in;
		end
	end

	// table memory, read before write at the same edge keeps item order
	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem[wr_idx] <= wr_entry;
		end
		if (ready_s2 && v_s1) begin
			data_s2.entry  <= seg_mem[seg_s1];
			data_s2.offset <= off_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

`ifndef ASSERT_OFF
	// a convert transfer always lands in stage 1
	a_conv_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (operation == OP_CONVERT)) |=> v_s1)
		else $error("convert transfer did not enter stage 1");

	// a write transfer leaves no item behind
	a_write_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (operation == OP_WRITE)) |=> !v_s1)
		else $error("write transfer created a pipeline item");

	// back-pressure only when both stages are full and downstream stalls
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && !out_ready))
		else $error("input stalled with a free stage");
`endif

endmodule

[src/esl_mult.sv]
// ----------------------------------------------------------------------------
// esl_mult
// Multiply stage: segment offset times the signed segment span.
// ----------------------------------------------------------------------------
module esl_mult import esl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  esl_s2_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output esl_s3_t out_data
);

	logic                     v_s3;
	esl_s3_t                  data_s3;
	logic signed [PROD_W-1:0] prod;

	assign in_ready = !v_s3 || out_ready;

	// offset is unsigned, widen with a zero sign bit
	assign prod = PROD_W'($signed({1'b0, in_data.offset}) * in_data.entry.span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.prod     <= prod;
			data_s3.lo_angle <= in_data.entry.lo_angle;
			data_s3.hi_angle <= in_data.entry.hi_angle;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

[src/esl_out.sv]
// ----------------------------------------------------------------------------
// esl_out
// Output stage: divide by the segment width toward zero, apply the segment
// base in the chosen direction, saturate and hold in the output register.
// ----------------------------------------------------------------------------
module esl_out import esl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     count_up,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  esl_s3_t                  in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ELEC_W-1:0] electric_angle
);

	localparam logic signed [PROD_W-1:0] OUT_LO = PROD_W'(-(2 ** (ELEC_W - 1)));
	localparam logic signed [PROD_W-1:0] OUT_HI = PROD_W'((2 ** (ELEC_W - 1)) - 1);

	logic                     v_s4;
	logic signed [ELEC_W-1:0] angle_s4;
	logic signed [PROD_W-1:0] bias;
	logic signed [PROD_W-1:0] quot;
	logic signed [PROD_W-1:0] lo_ext;
	logic signed [PROD_W-1:0] hi_ext;
	logic signed [PROD_W-1:0] sum;
	logic signed [ELEC_W-1:0] sat;

	assign in_ready = !v_s4 || out_ready;

	// shift with rounding toward zero for negative products
	assign bias = in_data.prod[PROD_W-1] ? PROD_W'(SEGMENT_WIDTH - 1) : '0;
	assign quot = (in_data.prod + bias) >>> OFF_W;

	// segment base, up from the minimum or down from the maximum
	assign lo_ext = $signed(PROD_W'(in_data.lo_angle));
	assign hi_ext = $signed(PROD_W'(in_data.hi_angle));
	assign sum    = count_up ? (lo_ext + quot) : (hi_ext - quot);

	// clamp to the output range
	always_comb begin
		if (sum < OUT_LO) begin
			sat = OUT_LO[ELEC_W-1:0];
		end else if (sum > OUT_HI) begin
			sat = OUT_HI[ELEC_W-1:0];
		end else begin
			sat = sum[ELEC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			angle_s4 <= sat;
		end
	end

	assign out_valid      = v_s4;
	assign electric_angle = angle_s4;

endmodule
